>>> rtl/rrsa_pkg.sv
// ----------------------------------------------------------------------------
// rrsa_pkg
// Shared types and constants of the round-robin slot id allocator.
// ----------------------------------------------------------------------------
package rrsa_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int ID_W       = $clog2(SLOT_COUNT);

  localparam int BASE_W     = 48;
  localparam int SHIFT_W    = 6;
  localparam int RID_W      = 6;
  localparam int OUT_ID_W   = 6;
  localparam int ADDR_W     = 64;
  localparam int CFG_IDX_W  = 1;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(32);

  typedef logic [ID_W-1:0] id_t;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_BUSY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIRTUAL_BASE = 1'b0,
    CFG_SLOT_SHIFT   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic             kind;
    logic [RID_W-1:0] release_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OUT_ID_W-1:0] slot_id;
    logic [ADDR_W-1:0]   slot_address;
  } out_word_t;

  typedef struct packed {
    logic en;
    id_t  addr;
    logic busy;
  } map_wr_t;

  function automatic id_t next_id(input id_t id);
    return (id == ID_W'(SLOT_COUNT - 1)) ? '0 : id + 1'b1;
  endfunction

endpackage

>>> rtl/rrsa_busy_map.sv
// ----------------------------------------------------------------------------
// rrsa_busy_map
// Busy bitmap in a synchronous memory with a registered read, with
// per-entry valid bits so reset frees every slot at once.
// ----------------------------------------------------------------------------
module rrsa_busy_map (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rd_en,
  input  rrsa_pkg::id_t  rd_addr,
  output logic           rd_busy,
  input  rrsa_pkg::map_wr_t wr
);
  import rrsa_pkg::*;

  logic                  mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;
  logic                  rd_busy_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_busy_r <= valid_r[rd_addr] & mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_busy = rd_busy_r;

endmodule

>>> rtl/round_robin_slot_id_allocator.sv
// ----------------------------------------------------------------------------
// round_robin_slot_id_allocator
// Allocates slot ids round robin from a busy bitmap and releases them;
// returns the granted id and its address in the reserved region.
// ----------------------------------------------------------------------------
// allocate: one bitmap probe per cycle, k probes (1..SLOT_COUNT) until a free
//   slot or a full sweep; the result word is registered after the last probe
// release: one bitmap read, then a registered result word
// a new word can start in the cycle its predecessor's result is shown
// reset frees every slot at once, last granted id 0, base 0, shift 32
module round_robin_slot_id_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  rrsa_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  output rrsa_pkg::out_word_t                out_word,
  input  logic                               cfg_we,
  input  logic [rrsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrsa_pkg::BASE_W-1:0]        cfg_data
);
  import rrsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_REL  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  id_t                 probe_r, probe_nxt;
  id_t                 cnt_r, cnt_nxt;
  id_t                 last_r, last_nxt;
  id_t                 rel_id_r, rel_id_nxt;
  logic                rel_ok_r, rel_ok_nxt;
  logic [BASE_W-1:0]   vbase_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  logic                rd_en;
  id_t                 rd_addr;
  logic                rd_busy;
  map_wr_t             wr;
  id_t                 first_probe;
  id_t                 scan_next;
  logic [ADDR_W-1:0]   grant_addr;

  rrsa_busy_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_busy (rd_busy),
    .wr      (wr)
  );

  assign first_probe = next_id(last_r);
  assign scan_next   = next_id(probe_r);
  assign grant_addr  = ADDR_W'(vbase_r) + (ADDR_W'(probe_r) << shift_r);

  always_comb begin
    state_nxt     = state_r;
    probe_nxt     = probe_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    rel_id_nxt    = rel_id_r;
    rel_ok_nxt    = rel_ok_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    rd_en         = 1'b0;
    rd_addr       = probe_r;
    wr            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_word.kind == KIND_ALLOC) begin
            rd_en     = 1'b1;
            rd_addr   = first_probe;
            probe_nxt = first_probe;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = ID_W'(in_word.release_id);
            rel_id_nxt = ID_W'(in_word.release_id);
            rel_ok_nxt = (32'(in_word.release_id) < 32'(SLOT_COUNT));
            state_nxt  = S_REL;
          end
        end
      end
      S_SCAN: begin
        if (!rd_busy) begin
          wr.en                     = 1'b1;
          wr.addr                   = probe_r;
          wr.busy                   = 1'b1;
          last_nxt                  = probe_r;
          out_valid_nxt             = 1'b1;
          out_word_nxt.status       = ST_OK;
          out_word_nxt.slot_id      = OUT_ID_W'(probe_r);
          out_word_nxt.slot_address = grant_addr;
          state_nxt                 = S_IDLE;
        end else if (cnt_r == ID_W'(SLOT_COUNT - 1)) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.status       = ST_FULL;
          out_word_nxt.slot_id      = '0;
          out_word_nxt.slot_address = '0;
          state_nxt                 = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = scan_next;
          probe_nxt = scan_next;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      S_REL: begin
        out_valid_nxt             = 1'b1;
        out_word_nxt.slot_id      = '0;
        out_word_nxt.slot_address = '0;
        if (rel_ok_r && rd_busy) begin
          wr.en               = 1'b1;
          wr.addr             = rel_id_r;
          wr.busy             = 1'b0;
          out_word_nxt.status = ST_OK;
        end else begin
          out_word_nxt.status = ST_NOT_BUSY;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r    <= probe_nxt;
    cnt_r      <= cnt_nxt;
    rel_id_r   <= rel_id_nxt;
    rel_ok_r   <= rel_ok_nxt;
    out_word_r <= out_word_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbase_r <= '0;
      shift_r <= SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VIRTUAL_BASE: vbase_r <= cfg_data;
        CFG_SLOT_SHIFT:   shift_r <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_SCAN || $past(state_r) == S_REL))
    else $error("result word without a finished request");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  a_full_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == ST_FULL) |->
      (out_word_r.slot_id == '0 && out_word_r.slot_address == '0))
    else $error("full result carries an id or address");

  a_grant_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && $past(state_r) == S_SCAN && out_word_r.status == ST_OK) |->
      (out_word_r.slot_id == OUT_ID_W'(last_r)))
    else $error("granted id differs from last granted id");
`endif

endmodule

>>> sim/rrsa_checker.sv
// ----------------------------------------------------------------------------
// rrsa_checker
// Watches the request, reply and register ports of the slot id allocator,
// keeps its own busy map, last grant and register copies, works out the
// reply of every accepted word and compares the replies field by field.
// ----------------------------------------------------------------------------
module rrsa_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  rrsa_pkg::in_word_t             in_word,
  input  logic                           out_valid,
  input  rrsa_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [rrsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrsa_pkg::BASE_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             waiting
);
  import rrsa_pkg::*;

  logic [SLOT_COUNT-1:0] slot_taken;
  logic [ID_W-1:0]       last_grant;
  logic [BASE_W-1:0]     base_reg;
  logic [SHIFT_W-1:0]    shift_reg;
  out_word_t             pending_replies[$];
  out_word_t             want;

  initial begin
    fail_count = 0;
    waiting    = 0;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // updates the busy map and last grant as the block should
  function automatic out_word_t compute_reply(input in_word_t w);
    out_word_t       r;
    logic [ID_W-1:0] probe;
    bit              found;
    r     = '0;
    found = 1'b0;
    if (w.kind == KIND_ALLOC) begin
      probe = last_grant + 1'b1;
      for (int n = 0; n < SLOT_COUNT; n++) begin
        if (!found && !slot_taken[probe]) begin
          found = 1'b1;
        end else if (!found) begin
          probe = probe + 1'b1;
        end
      end
      if (found) begin
        slot_taken[probe] = 1'b1;
        last_grant        = probe;
        r.status          = ST_OK;
        r.slot_id         = probe;
        r.slot_address    = ADDR_W'(base_reg) + (ADDR_W'(probe) << shift_reg);
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      if (slot_taken[w.release_id]) begin
        slot_taken[w.release_id] = 1'b0;
        r.status                 = ST_OK;
      end else begin
        r.status = ST_NOT_BUSY;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_taken = '0;
      last_grant = '0;
      base_reg   = '0;
      shift_reg  = SHIFT_RESET;
      pending_replies.delete();
    end else begin
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          report($sformatf("reply %0h with no word outstanding", out_word));
        end else begin
          want = pending_replies.pop_front();
          if (out_word.status !== want.status)
            report($sformatf("status %0d, expected %0d", out_word.status, want.status));
          if (out_word.slot_id !== want.slot_id)
            report($sformatf("slot_id %0d, expected %0d", out_word.slot_id, want.slot_id));
          if (out_word.slot_address !== want.slot_address)
            report($sformatf("slot_address %0h, expected %0h",
                             out_word.slot_address, want.slot_address));
        end
      end
      if (start && !busy)
        pending_replies.push_back(compute_reply(in_word));
      if (cfg_we) begin
        case (cfg_index)
          CFG_VIRTUAL_BASE: base_reg  = cfg_data;
          CFG_SLOT_SHIFT:   shift_reg = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
    waiting = pending_replies.size();
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and release words into the slot id allocator through a
// short directed run and register phases of biased random traffic, then
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  import rrsa_pkg::*;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int PHASES         = 10;
  localparam int WORDS_PER_PHASE = 123;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [BASE_W-1:0]     cfg_data  = '0;
  int                    fail_count;
  int                    waiting;
  int                    cycles    = 0;
  bit                    idle_on   = 1'b0;

  round_robin_slot_id_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rrsa_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [BASE_W-1:0] rand_base();
    return BASE_W'({$urandom, $urandom});
  endfunction

  // one word, held until accepted; optional idle burst afterwards
  task automatic issue(input kind_t k, input logic [RID_W-1:0] id);
    in_word_t w;
    w.kind       = k;
    w.release_id = id;
    start   <= 1'b1;
    in_word <= w;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (idle_on && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // upper data bits of the shift write are junk on purpose
  task automatic write_config(input logic [BASE_W-1:0] base, input logic [SHIFT_W-1:0] shift);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VIRTUAL_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= CFG_SLOT_SHIFT;
    cfg_data  <= (rand_base() << SHIFT_W) | BASE_W'(shift);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [BASE_W-1:0]  base;
    logic [SHIFT_W-1:0] shift;
    int                 alloc_pct;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: release of free slots, grants from reset, double release
    issue(KIND_RELEASE, 6'd0);
    issue(KIND_RELEASE, 6'd63);
    issue(KIND_ALLOC, 6'd63);
    issue(KIND_ALLOC, 6'd0);
    issue(KIND_RELEASE, 6'd1);
    issue(KIND_RELEASE, 6'd1);
    issue(KIND_ALLOC, 6'd42);
    issue(KIND_RELEASE, 6'd2);
    drain();
    // top base and shift, address wraps past 2^64
    write_config({BASE_W{1'b1}}, 6'd63);
    issue(KIND_ALLOC, 6'd21);
    issue(KIND_ALLOC, 6'd0);
    drain();
    write_config('0, 6'd0);
    issue(KIND_ALLOC, 6'd63);
    issue(KIND_RELEASE, 6'd6);
    issue(KIND_RELEASE, 6'd5);
    issue(KIND_RELEASE, 6'd4);
    issue(KIND_RELEASE, 6'd3);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin base = '0;              shift = 6'd12; end
        1:       begin base = {BASE_W{1'b1}};  shift = 6'd40; end
        2:       begin base = rand_base();     shift = 6'd0;  end
        3:       begin base = rand_base();     shift = 6'd63; end
        default: begin base = rand_base();     shift = SHIFT_W'($urandom_range(12, 40)); end
      endcase
      write_config(base, shift);
      case (p % 3)
        0:       alloc_pct = 95;
        1:       alloc_pct = 15;
        default: alloc_pct = 55;
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        idle_on = (p != PHASES - 1) && ((i / 40) % 2 == 0);
        if ($urandom_range(0, 99) < alloc_pct)
          issue(KIND_ALLOC, RID_W'($urandom));
        else
          issue(KIND_RELEASE, RID_W'($urandom));
      end
      idle_on = 1'b0;
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
